/* sv/pim_pkg.sv */
package pim_pkg;

    localparam int QUEUE_DEPTH_DEF  = 16;
    localparam int TASK_ID_BITS_DEF = 8;
    localparam int PRIO_BITS_DEF    = 8;
    localparam int CMD_FIFO_DEPTH   = 2;

    typedef enum logic [1:0] {
        REQ_LOCK    = 2'd0,
        REQ_UNLOCK  = 2'd1,
        REQ_TIMEOUT = 2'd2,
        REQ_DELETE  = 2'd3
    } t_req;

    typedef enum logic [3:0] {
        ST_GRANTED     = 4'd0,
        ST_UNAVAIL     = 4'd1,
        ST_QUEUED      = 4'd2,
        ST_QFULL       = 4'd3,
        ST_ILLEGAL     = 4'd4,
        ST_NOT_LOCKED  = 4'd5,
        ST_RELEASED    = 4'd6,
        ST_HANDED      = 4'd7,
        ST_TO_REMOVED  = 4'd8,
        ST_TO_OWNER    = 4'd9,
        ST_TO_UNKNOWN  = 4'd10,
        ST_DELETED     = 4'd11
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SEARCH,
        S_SHIFT,
        S_MIN,
        S_DELETE,
        S_EMIT
    } t_state;

endpackage

/* sv/pim_front.sv */
module pim_front #(
    parameter int TASK_ID_BITS = pim_pkg::TASK_ID_BITS_DEF,
    parameter int PRIO_BITS    = pim_pkg::PRIO_BITS_DEF,
    parameter int CMD_W        = 3 + TASK_ID_BITS + PRIO_BITS
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [CMD_W-1:0] o_cmd
);
    localparam int D  = pim_pkg::CMD_FIFO_DEPTH;
    localparam int AW = $clog2(D);

    logic [CMD_W-1:0] r_mem [D];
    logic [AW-1:0]    r_wp, r_rp;
    logic [AW:0]      r_cnt;
    logic             push, pop;

    assign o_ready = (r_cnt != (AW+1)'(D));
    assign o_valid = (r_cnt != '0);
    assign push    = i_valid && o_ready;
    assign pop     = o_valid && i_ready;
    assign o_cmd   = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (push) begin
                r_wp <= (r_wp == AW'(D-1)) ? '0 : r_wp + 1'b1;
            end
            if (pop) begin
                r_rp <= (r_rp == AW'(D-1)) ? '0 : r_rp + 1'b1;
            end
            r_cnt <= r_cnt + (AW+1)'(push) - (AW+1)'(pop);
        end
    end

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= (AW+1)'(D)) else $error("fifo count overflow");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cnt == (AW+1)'(D)) |-> !push) else $error("push while full");
    a_pop_dec: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !push) |=> (r_cnt == $past(r_cnt) - 1'b1)) else $error("pop count");
endmodule

/* sv/pim_back.sv */
module pim_back #(
    parameter int QUEUE_DEPTH  = pim_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = pim_pkg::TASK_ID_BITS_DEF,
    parameter int PRIO_BITS    = pim_pkg::PRIO_BITS_DEF,
    parameter int CMD_W        = 3 + TASK_ID_BITS + PRIO_BITS,
    parameter int RES_W        = 4 + 3 + 3 * TASK_ID_BITS + 2 * PRIO_BITS + 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_inherit,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [CMD_W-1:0] i_cmd,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [RES_W-1:0] o_res
);
    localparam int QW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CW = $clog2(QUEUE_DEPTH + 1);
    localparam int IW = TASK_ID_BITS;
    localparam int PW = PRIO_BITS;

    pim_pkg::t_state r_st, n_st;

    logic [IW-1:0] r_ids   [QUEUE_DEPTH];
    logic [PW-1:0] r_prios [QUEUE_DEPTH];
    logic [CW-1:0] r_cnt, n_cnt;
    logic          r_locked, n_locked;
    logic [IW-1:0] r_oid, n_oid;
    logic [PW-1:0] r_obase, n_obase, r_oeff, n_oeff;
    logic [CW-1:0] r_idx, n_idx;
    logic [PW-1:0] r_min, n_min;
    logic [PW-1:0] r_rmp, n_rmp;
    logic          r_unl, n_unl;
    logic [IW-1:0] r_tid, n_tid;

    logic          r_ov, n_ov;
    pim_pkg::t_status r_status, n_status;
    logic          r_wv, n_wv, r_rv, n_rv, r_last, n_last;
    logic [IW-1:0] r_wt, n_wt, r_rt, n_rt;
    logic [PW-1:0] r_rp, n_rp;
    logic          r_pend, n_pend;

    logic          wr_en;
    logic [QW-1:0] wr_a;
    logic [IW-1:0] wr_id;
    logic [PW-1:0] wr_pr;

    pim_pkg::t_req c_req;
    logic [IW-1:0] c_tid;
    logic [PW-1:0] c_prio;
    logic          c_mw;
    logic [QW-1:0] ix;
    logic          take;

    assign c_req  = pim_pkg::t_req'(i_cmd[1:0]);
    assign c_tid  = i_cmd[2 +: IW];
    assign c_prio = i_cmd[2+IW +: PW];
    assign c_mw   = i_cmd[2+IW+PW];
    assign ix     = r_idx[QW-1:0];
    assign o_ready = (r_st == pim_pkg::S_IDLE) && !r_pend && (!r_ov || i_ready);
    assign take   = i_valid && o_ready;
    assign o_valid = r_ov;
    assign o_res = {r_last,
                    r_rv ? r_rp : PW'(0), r_rv ? r_rt : IW'(0), r_rv,
                    r_locked ? r_oeff : PW'(0), r_locked ? r_oid : IW'(0), r_locked,
                    r_wv ? r_wt : IW'(0), r_wv, r_status};

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_ids[wr_a]   <= wr_id;
            r_prios[wr_a] <= wr_pr;
        end
    end

    always_comb begin
        n_st = r_st; n_cnt = r_cnt; n_locked = r_locked; n_oid = r_oid;
        n_obase = r_obase; n_oeff = r_oeff; n_idx = r_idx; n_min = r_min;
        n_rmp = r_rmp; n_unl = r_unl; n_tid = r_tid;
        n_ov = r_ov; n_status = r_status; n_wv = r_wv; n_rv = r_rv; n_last = r_last;
        n_wt = r_wt; n_rt = r_rt; n_rp = r_rp; n_pend = r_pend;
        wr_en = 1'b0; wr_a = r_cnt[QW-1:0]; wr_id = c_tid; wr_pr = c_prio;
        if (r_ov && i_ready) begin
            n_ov = 1'b0;
        end
        if (r_pend && !n_ov) begin
            n_ov = 1'b1;
            n_pend = 1'b0;
        end
        case (r_st)
            pim_pkg::S_IDLE: begin
                if (take) begin
                    n_wv = 1'b0; n_rv = 1'b0; n_last = 1'b1; n_tid = c_tid;
                    n_pend = 1'b1; n_idx = '0;
                    case (c_req)
                        pim_pkg::REQ_LOCK: begin
                            if (!r_locked) begin
                                n_locked = 1'b1; n_oid = c_tid;
                                n_obase = c_prio; n_oeff = c_prio;
                                n_status = pim_pkg::ST_GRANTED;
                            end else if (!c_mw) begin
                                n_status = pim_pkg::ST_UNAVAIL;
                            end else if (r_cnt >= CW'(QUEUE_DEPTH)) begin
                                n_status = pim_pkg::ST_QFULL;
                            end else begin
                                wr_en = 1'b1;
                                n_cnt = r_cnt + 1'b1;
                                if (i_inherit && r_oeff > c_prio) begin
                                    n_oeff = c_prio;
                                end
                                n_status = pim_pkg::ST_QUEUED;
                            end
                        end
                        pim_pkg::REQ_UNLOCK: begin
                            if (!r_locked) begin
                                n_status = pim_pkg::ST_NOT_LOCKED;
                            end else if (r_oid != c_tid) begin
                                n_status = pim_pkg::ST_ILLEGAL;
                            end else begin
                                n_rv = (r_oeff != r_obase); n_rt = r_oid; n_rp = r_obase;
                                if (r_cnt != '0) begin
                                    n_oid = r_ids[0]; n_obase = r_prios[0];
                                    n_oeff = r_prios[0]; n_min = r_prios[0];
                                    n_wv = 1'b1; n_wt = r_ids[0];
                                    n_status = pim_pkg::ST_HANDED;
                                    n_unl = 1'b1; n_pend = 1'b0;
                                    n_st = pim_pkg::S_SHIFT;
                                end else begin
                                    n_locked = 1'b0; n_oid = '0;
                                    n_obase = '0; n_oeff = '0;
                                    n_status = pim_pkg::ST_RELEASED;
                                end
                            end
                        end
                        pim_pkg::REQ_TIMEOUT: begin
                            if (r_locked && r_oid == c_tid) begin
                                n_status = pim_pkg::ST_TO_OWNER;
                            end else begin
                                n_pend = 1'b0; n_unl = 1'b0;
                                n_st = pim_pkg::S_SEARCH;
                            end
                        end
                        default: begin
                            n_locked = 1'b0; n_oid = '0; n_obase = '0; n_oeff = '0;
                            n_status = pim_pkg::ST_DELETED;
                            if (r_cnt != '0) begin
                                n_pend = 1'b0;
                                n_st = pim_pkg::S_DELETE;
                            end
                        end
                    endcase
                end
            end
            pim_pkg::S_SEARCH: begin
                if (r_idx >= r_cnt) begin
                    n_status = pim_pkg::ST_TO_UNKNOWN;
                    n_st = pim_pkg::S_EMIT;
                end else if (r_ids[ix] == r_tid) begin
                    n_rmp = r_prios[ix];
                    n_wv = 1'b1; n_wt = r_tid;
                    n_status = pim_pkg::ST_TO_REMOVED;
                    n_st = pim_pkg::S_SHIFT;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            pim_pkg::S_SHIFT: begin
                if (r_idx + 1'b1 < r_cnt) begin
                    wr_en = 1'b1; wr_a = ix;
                    wr_id = r_ids[QW'(r_idx + 1'b1)];
                    wr_pr = r_prios[QW'(r_idx + 1'b1)];
                    n_idx = r_idx + 1'b1;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                    n_idx = '0;
                    if (r_unl) begin
                        n_st = i_inherit ? pim_pkg::S_MIN : pim_pkg::S_EMIT;
                    end else if (r_locked && i_inherit && r_oeff == r_rmp) begin
                        n_min = r_obase;
                        n_st = pim_pkg::S_MIN;
                    end else begin
                        n_st = pim_pkg::S_EMIT;
                    end
                end
            end
            pim_pkg::S_MIN: begin
                if (r_idx >= r_cnt) begin
                    n_oeff = r_min;
                    n_st = pim_pkg::S_EMIT;
                end else begin
                    if (r_prios[ix] < r_min) begin
                        n_min = r_prios[ix];
                    end
                    n_idx = r_idx + 1'b1;
                end
            end
            pim_pkg::S_DELETE: begin
                if (!n_ov) begin
                    n_ov = 1'b1;
                    n_wv = 1'b1; n_wt = r_ids[ix];
                    n_last = (r_idx + 1'b1 == r_cnt);
                    if (r_idx + 1'b1 == r_cnt) begin
                        n_cnt = '0; n_idx = '0;
                        n_st = pim_pkg::S_IDLE;
                    end else begin
                        n_idx = r_idx + 1'b1;
                    end
                end
            end
            pim_pkg::S_EMIT: begin
                n_pend = 1'b1;
                n_st = pim_pkg::S_IDLE;
            end
            default: n_st = pim_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= pim_pkg::S_IDLE; r_cnt <= '0; r_locked <= 1'b0; r_oid <= '0;
            r_obase <= '0; r_oeff <= '0; r_ov <= 1'b0; r_pend <= 1'b0;
        end else begin
            r_st <= n_st; r_cnt <= n_cnt; r_locked <= n_locked; r_oid <= n_oid;
            r_obase <= n_obase; r_oeff <= n_oeff; r_ov <= n_ov; r_pend <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_idx <= n_idx; r_min <= n_min; r_rmp <= n_rmp; r_unl <= n_unl; r_tid <= n_tid;
        r_status <= n_status; r_wv <= n_wv; r_rv <= n_rv; r_last <= n_last;
        r_wt <= n_wt; r_rt <= n_rt; r_rp <= n_rp;
    end

    a_cnt_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(QUEUE_DEPTH)) else $error("queue count overflow");
    a_q_needs_owner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == pim_pkg::S_IDLE && r_cnt != '0) |-> r_locked)
        else $error("waiters without owner");
    a_take_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        take |=> (r_pend || r_st != pim_pkg::S_IDLE)) else $error("item dropped");
endmodule

/* sv/priority_inheritance_mutex.sv */
// Unlock handover, timeout and delete step serially through the waiter array
// in the back end (queue search, shift and minimum); the back end takes no new
// command until the one before is through. Delete emits one result a cycle,
// one per waiter, while m_axis_tready is held high.
// Reset: synchronous active-low; mutex free, queue empty, inherit_enable 1.
module priority_inheritance_mutex #(
    parameter int QUEUE_DEPTH  = pim_pkg::QUEUE_DEPTH_DEF,
    parameter int TASK_ID_BITS = pim_pkg::TASK_ID_BITS_DEF,
    parameter int PRIO_BITS    = pim_pkg::PRIO_BITS_DEF,
    parameter int IN_W  = 3 + TASK_ID_BITS + PRIO_BITS,
    parameter int RES_W = 4 + 3 + 3 * TASK_ID_BITS + 2 * PRIO_BITS + 1
) (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    input  logic i_cfg_data,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    // req_type, task_id, task_prio, may_wait, zero fill
    input  logic [((IN_W+7)/8)*8-1:0] s_axis_tdata,
    output logic m_axis_tvalid,
    input  logic m_axis_tready,
    // status, wake_valid, wake_task, owner_valid, owner_task, owner_prio,
    // restore_valid, restore_task, restore_prio, zero fill
    output logic [((RES_W-1+7)/8)*8-1:0] m_axis_tdata,
    output logic m_axis_tlast
);
    localparam int OW = ((RES_W-1+7)/8)*8;

    logic            r_inherit;
    logic            fv, fr;
    logic [IN_W-1:0] fcmd;
    logic [RES_W-1:0] res;

    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_inherit <= 1'b1;
        end else if (i_cfg_valid) begin
            r_inherit <= i_cfg_data;
        end
    end

    pim_front #(.TASK_ID_BITS(TASK_ID_BITS), .PRIO_BITS(PRIO_BITS), .CMD_W(IN_W)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_cmd(s_axis_tdata[IN_W-1:0]),
        .o_valid(fv), .i_ready(fr), .o_cmd(fcmd)
    );

    pim_back #(.QUEUE_DEPTH(QUEUE_DEPTH), .TASK_ID_BITS(TASK_ID_BITS),
               .PRIO_BITS(PRIO_BITS), .CMD_W(IN_W), .RES_W(RES_W)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_inherit(r_inherit),
        .i_valid(fv), .o_ready(fr), .i_cmd(fcmd),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready), .o_res(res)
    );

    assign m_axis_tdata = OW'(res[RES_W-2:0]);
    assign m_axis_tlast = res[RES_W-1];
endmodule
